FILE: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types and codes of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int GROUP_N  = 3;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_CHR = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] char_code;
		logic              end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   byte_out;
		logic [STATUS_W-1:0] status;
		logic                final_result;
	} out_item_t;

	// results of one input transaction, handed from decode to output buffer
	typedef struct packed {
		logic                           valid;
		logic [1:0]                     last_idx;
		logic [GROUP_N-1:0][BYTE_W-1:0] bytes;
		logic [STATUS_W-1:0]            status;
		logic                           final_result;
	} group_t;

endpackage

FILE: rtl/b64d_core.sv
// ----------------------------------------------------------------------------
// b64d_core
// input register, group state and character decode
// ----------------------------------------------------------------------------
module b64d_core import b64d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	output group_t   grp,
	input  logic     grp_ready
);

	localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

	// bit 6 set: not in the alphabet
	function automatic logic [6:0] sextet_of(input logic [BYTE_W-1:0] c);
		logic [6:0] r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B) r = 7'd62;
		else if (c == 8'h2F) r = 7'd63;
		return r;
	endfunction

	logic        valid_s1;
	in_item_t    item_s1;
	logic [17:0] store_q, store_n;
	logic [1:0]  gpos_q, gpos_n;
	logic [1:0]  pad_q, pad_n;
	logic        padded_q, padded_n;
	logic        err_q, err_n;
	logic [1:0]  cnt;
	logic [6:0]  v;
	logic        is_pad, bad, fire_s1;
	logic [23:0] word;
	logic [5:0]  sv;

	always_comb begin
		store_n  = store_q;
		gpos_n   = gpos_q;
		pad_n    = pad_q;
		padded_n = padded_q;
		err_n    = err_q;
		cnt      = 2'd0;
		word     = {store_q, 6'd0};
		is_pad   = (item_s1.char_code == PAD_CHAR);
		v        = sextet_of(item_s1.char_code);
		sv       = is_pad ? 6'd0 : v[5:0];
		if (padded_q) bad = 1'b1;
		else if (is_pad) bad = (gpos_q < 2'd2);
		else bad = v[6] || (pad_q != 2'd0);

		if (!err_q) begin
			if (bad) begin
				err_n = 1'b1;
			end else begin
				pad_n = pad_q + {1'b0, is_pad};
				if (gpos_q != 2'd3) begin
					store_n = {store_q[11:0], sv};
					gpos_n  = gpos_q + 2'd1;
				end else begin
					word     = {store_q, sv};
					cnt      = 2'd3 - pad_n;
					padded_n = (pad_n != 2'd0);
					store_n  = '0;
					gpos_n   = 2'd0;
					pad_n    = 2'd0;
				end
			end
		end

		grp.valid        = valid_s1 && ((cnt != 2'd0) || item_s1.end_of_message);
		grp.last_idx     = cnt - 2'd1;
		grp.bytes[0]     = word[23:16];
		grp.bytes[1]     = word[15:8];
		grp.bytes[2]     = word[7:0];
		grp.status       = STATUS_OK;
		grp.final_result = item_s1.end_of_message;

		if (item_s1.end_of_message) begin
			if (err_n) begin
				grp.last_idx = 2'd0;
				grp.bytes    = '0;
				grp.status   = STATUS_BAD_CHR;
			end else if (gpos_n != 2'd0 || cnt == 2'd0) begin
				grp.last_idx = 2'd0;
				grp.bytes    = '0;
				grp.status   = STATUS_BAD_LEN;
			end
			store_n  = '0;
			gpos_n   = 2'd0;
			pad_n    = 2'd0;
			padded_n = 1'b0;
			err_n    = 1'b0;
		end
	end

	assign fire_s1  = valid_s1 && (!grp.valid || grp_ready);
	assign in_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			store_q  <= '0;
			gpos_q   <= '0;
			pad_q    <= '0;
			padded_q <= 1'b0;
			err_q    <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (fire_s1) begin
				store_q  <= store_n;
				gpos_q   <= gpos_n;
				pad_q    <= pad_n;
				padded_q <= padded_n;
				err_q    <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_item;
	end

endmodule

FILE: rtl/b64d_outbuf.sv
// ----------------------------------------------------------------------------
// b64d_outbuf
// result register, hands out up to three bytes one transaction at a time
// ----------------------------------------------------------------------------
module b64d_outbuf import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  group_t    grp,
	output logic      grp_ready,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic                           valid_s2;
	logic [1:0]                     idx_q;
	logic [1:0]                     last_idx_s2;
	logic [GROUP_N-1:0][BYTE_W-1:0] bytes_s2;
	logic [STATUS_W-1:0]            status_s2;
	logic                           final_s2;
	logic                           at_last;

	assign at_last   = (idx_q == last_idx_s2);
	assign grp_ready = !valid_s2 || (!out_stall && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (grp.valid && grp_ready) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (valid_s2 && !out_stall) begin
			if (at_last) valid_s2 <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp.valid && grp_ready) begin
			last_idx_s2 <= grp.last_idx;
			bytes_s2    <= grp.bytes;
			status_s2   <= grp.status;
			final_s2    <= grp.final_result;
		end
	end

	assign out_valid             = valid_s2;
	assign out_item.byte_out     = bytes_s2[idx_q];
	assign out_item.status       = status_s2;
	assign out_item.final_result = final_s2 && at_last;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q <= last_idx_s2 && last_idx_s2 != 2'd3))
		else $error("result index past group end");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != STATUS_OK) |->
		(out_item.final_result && out_item.byte_out == '0))
		else $error("error result not a lone final zero byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> (valid_s2 && $stable(idx_q)))
		else $error("stalled result lost");

endmodule

FILE: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   char_code, end_of_message
// out      output     out_valid/out_stall byte_out, status, final_result
//
// one character per cycle unless stalled; input register, then result register
// a completed group gives up to three results, one per cycle while out_stall is low
// a character that brings results stalls while earlier results are still handed out
// reset clears group state and the valid flags of input and result registers
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	group_t grp;
	logic   grp_ready;

	b64d_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.grp       (grp),
		.grp_ready (grp_ready)
	);

	b64d_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.grp_ready (grp_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

FILE: tb/b64d_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64d_checker
// watches both channels of the base64 stream decoder, works out the bytes
// and closing status that each accepted character should give, and compares
// every output transaction against the oldest outstanding expectation
// ----------------------------------------------------------------------------
module b64d_checker import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_item,
	output int        fails,
	output int        backlog
);

	localparam logic [7:0] PAD_CHAR  = 8'h3D;
	localparam logic [6:0] NO_SEXTET = 7'd64;
	localparam int         REPORT_N  = 10;

	out_item_t expected_results [$];

	logic [17:0] sextets;
	logic [1:0]  slot;
	logic [1:0]  pads;
	logic        padded_done;
	logic        char_error;

	function automatic logic [6:0] sextet_of(logic [7:0] c);
		if (c >= "A" && c <= "Z") return 7'(c - "A");
		if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
		if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
		if (c == "+") return 7'd62;
		if (c == "/") return 7'd63;
		return NO_SEXTET;
	endfunction

	task automatic clear_message();
		sextets     = '0;
		slot        = '0;
		pads        = '0;
		padded_done = 1'b0;
		char_error  = 1'b0;
	endtask

	task automatic decode_char(input in_item_t it);
		logic [6:0]  v;
		logic        pad;
		logic        bad;
		logic [5:0]  sv;
		logic [23:0] word;
		int          cnt;
		out_item_t   r;
		out_item_t   res [$];
		pad = (it.char_code == PAD_CHAR);
		v   = sextet_of(it.char_code);
		if (!char_error) begin
			if (padded_done)
				bad = 1'b1;
			else if (pad)
				bad = (slot < 2'd2);
			else
				bad = (v == NO_SEXTET) || (pads != 2'd0);
			if (bad) begin
				char_error = 1'b1;
			end else begin
				sv = pad ? 6'd0 : v[5:0];
				if (pad)
					pads = pads + 2'd1;
				if (slot < 2'd3) begin
					sextets = {sextets[11:0], sv};
					slot    = slot + 2'd1;
				end else begin
					word = {sextets, sv};
					cnt  = 3 - int'(pads);
					for (int i = 0; i < cnt; i++) begin
						r.byte_out     = word[23-8*i -: 8];
						r.status       = STATUS_OK;
						r.final_result = 1'b0;
						res.push_back(r);
					end
					if (pads != 2'd0)
						padded_done = 1'b1;
					sextets = '0;
					slot    = '0;
					pads    = '0;
				end
			end
		end
		if (it.end_of_message) begin
			if (char_error || slot != 2'd0 || res.size() == 0) begin
				res.delete();
				r.byte_out     = 8'd0;
				r.status       = char_error ? STATUS_BAD_CHR : STATUS_BAD_LEN;
				r.final_result = 1'b1;
				res.push_back(r);
			end else begin
				res[res.size()-1].final_result = 1'b1;
			end
			clear_message();
		end
		foreach (res[i])
			expected_results.push_back(res[i]);
	endtask

	task automatic note_failure(input string what, input out_item_t exp_r, input out_item_t got);
		fails++;
		if (fails <= REPORT_N)
			$display("%s: expected byte %02h status %0d final %0b, got byte %02h status %0d final %0b",
				what, exp_r.byte_out, exp_r.status, exp_r.final_result,
				got.byte_out, got.status, got.final_result);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			clear_message();
			expected_results.delete();
			fails   = 0;
			backlog = 0;
		end else begin
			if (in_valid && !in_stall)
				decode_char(in_item);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_failure("unexpected transaction", '0, out_item);
				end else begin
					exp_r = expected_results.pop_front();
					if (out_item.byte_out !== exp_r.byte_out || out_item.status !== exp_r.status
							|| out_item.final_result !== exp_r.final_result)
						note_failure("mismatch", exp_r, out_item);
				end
			end
			backlog = expected_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives encoded messages into the base64 stream decoder: a short directed
// set over alphabet edges and pad misuse, then random messages, mostly
// well-formed with random payload and pad trailers, plus truncated, corrupted
// and noise messages; both channels idle at random
// ----------------------------------------------------------------------------
module testbench;
	import b64d_pkg::*;

	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam int         ITEM_TARGET  = 170;
	localparam int         CALM_FROM    = 100;
	localparam int         CALM_TO      = 160;
	localparam int         CYCLE_LIMIT  = 100000;
	localparam int         SETTLE_CYCLE = 20;

	typedef enum int {
		MSG_CLEAN,
		MSG_SHORT,
		MSG_CORRUPT,
		MSG_TRAILER,
		MSG_NOISE
	} msg_kind_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	int        fails;
	int        backlog;
	int        cycles;
	int        chars_sent;
	bit        calm;
	logic [7:0] msg [$];

	base64_stream_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	b64d_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.fails    (fails),
		.backlog  (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 16);

	function automatic logic [7:0] b64_char(logic [5:0] v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		return (v == 6'd62) ? 8'("+") : 8'("/");
	endfunction

	task automatic append_encoded(input int nbytes, input bit padded);
		logic [23:0] word;
		int          k;
		for (int i = 0; i < nbytes; i += 3) begin
			k    = (nbytes - i >= 3) ? 3 : nbytes - i;
			word = 24'($urandom);
			msg.push_back(b64_char(word[23:18]));
			msg.push_back(b64_char(word[17:12]));
			if (k > 1)
				msg.push_back(b64_char(word[11:6]));
			else if (padded)
				msg.push_back(PAD_CHAR);
			if (k > 2)
				msg.push_back(b64_char(word[5:0]));
			else if (padded)
				msg.push_back(PAD_CHAR);
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		while (!calm && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{char_code: c, end_of_message: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
		calm = (chars_sent >= CALM_FROM && chars_sent < CALM_TO);
	endtask

	task automatic send_msg();
		foreach (msg[i])
			send_char(msg[i], i == msg.size() - 1);
		msg.delete();
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			msg.push_back(s[i]);
		send_msg();
	endtask

	initial begin
		msg_kind_t kind;
		int        idx;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		in_item    <= '0;
		chars_sent = 0;
		calm       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// alphabet edges, bytes outside the alphabet, pad trailers and pad misuse
		send_text("AZaz09+/");
		send_text("TR==");
		msg.push_back(8'hFF);
		msg.push_back(8'h00);
		send_msg();
		send_text("=");
		send_text("A=");
		send_text("TQ=A");
		send_text("TQ==A");
		send_text("TQ=");

		while (chars_sent < ITEM_TARGET) begin
			idx = $urandom_range(0, 9);
			kind = (idx < 6) ? MSG_CLEAN : msg_kind_t'(idx - 5);
			case (kind)
				MSG_CLEAN: begin
					append_encoded(($urandom_range(0, 7) == 0) ? $urandom_range(10, 15)
						: $urandom_range(1, 9), 1'b1);
				end
				MSG_SHORT: begin
					append_encoded($urandom_range(1, 9), $urandom_range(0, 1));
					if (msg.size() > 1 && $urandom_range(0, 1))
						repeat ($urandom_range(1, msg.size() - 1))
							void'(msg.pop_back());
				end
				MSG_CORRUPT: begin
					append_encoded($urandom_range(1, 9), 1'b1);
					idx = $urandom_range(0, msg.size() - 1);
					msg[idx] = ($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom);
				end
				MSG_TRAILER: begin
					append_encoded(3 * $urandom_range(0, 2) + $urandom_range(1, 2), 1'b1);
					append_encoded($urandom_range(1, 6), 1'b1);
				end
				default: begin
					repeat ($urandom_range(1, 6))
						msg.push_back(8'($urandom));
				end
			endcase
			send_msg();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLE) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
